// File: rtl/dnh_pkg.sv
`default_nettype none

package dnh_pkg;

    localparam int MAX_DEGREES_DEF = 12;
    localparam int MAJOR_LEN       = 7;
    localparam int OCTAVE          = 12;
    localparam int VEL_MAX         = 127;
    localparam int DIFF_INIT       = 99;
    localparam int ACC_W           = 10;
    localparam int VEL_RECIP       = 83887;
    localparam int VEL_SHIFT       = 23;

    localparam int PITCH_W   = 7;
    localparam int VEL_W     = 7;
    localparam int CHAN_W    = 4;
    localparam int TIME_W    = 31;
    localparam int LEN_W     = 31;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 48;
    localparam int RATIO_W   = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO   = 3'd4;

    localparam logic [3:0]            ROOT_RESET    = 4'd0;
    localparam logic [3:0]            SIZE_RESET    = 4'd7;
    localparam logic [CFG_DATA_W-1:0] DEGREES_RESET = 48'h0000_0B97_5420;
    localparam logic [RATIO_W-1:0]    RATIO_RESET   = 9'd100;

    typedef enum logic [2:0] {
        MODE_OCT_UP     = 3'd0,
        MODE_OCT_DOWN   = 3'd1,
        MODE_THIRD_UP   = 3'd2,
        MODE_THIRD_DOWN = 3'd3,
        MODE_FIFTH_UP   = 3'd4,
        MODE_FIFTH_DOWN = 3'd5,
        MODE_TRIAD      = 3'd6,
        MODE_SEVENTH    = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_SETUP,
        ST_WRAP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        mode_t                 mode;
        logic [3:0]            root;
        logic [3:0]            size;
        logic [CFG_DATA_W-1:0] degrees;
        logic [RATIO_W-1:0]    ratio;
    } cfg_t;

    function automatic logic [3:0] major_degree(input logic [2:0] i);
        logic [3:0] r;
        case (i)
            3'd0:    r = 4'd0;
            3'd1:    r = 4'd2;
            3'd2:    r = 4'd4;
            3'd3:    r = 4'd5;
            3'd4:    r = 4'd7;
            3'd5:    r = 4'd9;
            3'd6:    r = 4'd11;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] harm_count(input mode_t m);
        logic [1:0] r;
        case (m)
            MODE_TRIAD:   r = 2'd2;
            MODE_SEVENTH: r = 2'd3;
            default:      r = 2'd1;
        endcase
        return r;
    endfunction

    function automatic logic signed [3:0] harm_offset(input mode_t m, input logic [1:0] k);
        logic signed [3:0] r;
        case (m)
            MODE_THIRD_UP:   r = 4'sd2;
            MODE_THIRD_DOWN: r = -4'sd2;
            MODE_FIFTH_UP:   r = 4'sd4;
            MODE_FIFTH_DOWN: r = -4'sd4;
            MODE_TRIAD, MODE_SEVENTH:
            begin
                case (k)
                    2'd0:    r = 4'sd2;
                    2'd1:    r = 4'sd4;
                    default: r = 4'sd6;
                endcase
            end
            default:         r = 4'sd0;
        endcase
        return r;
    endfunction

    function automatic logic pitch_ok(input logic signed [ACC_W-1:0] p);
        return !p[ACC_W-1] && (p[ACC_W-2:PITCH_W] == '0);
    endfunction

endpackage

`default_nettype wire

// File: rtl/dnh_if.sv
`default_nettype none

interface dnh_note_if;
    import dnh_pkg::*;

    logic                valid;
    logic                ready;
    logic [PITCH_W-1:0]  note_pitch;
    logic [VEL_W-1:0]    note_velocity;
    logic [CHAN_W-1:0]   note_channel;
    logic [TIME_W-1:0]   note_time;
    logic [LEN_W-1:0]    note_length;

    modport source (
        output valid, note_pitch, note_velocity, note_channel, note_time, note_length,
        input  ready
    );

    modport sink (
        input  valid, note_pitch, note_velocity, note_channel, note_time, note_length,
        output ready
    );
endinterface

interface dnh_harmony_if;
    import dnh_pkg::*;

    logic                valid;
    logic                ready;
    logic [PITCH_W-1:0]  harmony_pitch;
    logic [VEL_W-1:0]    harmony_velocity;
    logic [CHAN_W-1:0]   harmony_channel;
    logic [TIME_W-1:0]   harmony_time;
    logic [LEN_W-1:0]    harmony_length;
    logic                last_of_run;

    modport source (
        output valid, harmony_pitch, harmony_velocity, harmony_channel, harmony_time,
               harmony_length, last_of_run,
        input  ready
    );

    modport sink (
        input  valid, harmony_pitch, harmony_velocity, harmony_channel, harmony_time,
               harmony_length, last_of_run,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/dnh_vel_scale.sv
`default_nettype none

module dnh_vel_scale (
    input  wire logic                        clk,
    input  wire logic [dnh_pkg::VEL_W-1:0]   velocity,
    input  wire logic [dnh_pkg::RATIO_W-1:0] ratio,
    output logic      [dnh_pkg::VEL_W-1:0]   scaled
);
    import dnh_pkg::*;

    localparam int PROD_W  = VEL_W + RATIO_W;
    localparam int QUOT_W  = 10;
    localparam int RECIP_W = 17;
    localparam int FULL_W  = PROD_W + RECIP_W;

    logic [PROD_W-1:0] prod_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [FULL_W-1:0] recip_prod;

    // Division by one hundred is a multiplication by a scaled reciprocal.
    assign recip_prod = FULL_W'(prod_reg) * FULL_W'(VEL_RECIP);

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(velocity) * PROD_W'(ratio);
        quot_reg <= recip_prod[VEL_SHIFT +: QUOT_W];
    end

    always_comb
    begin
        if (quot_reg == '0)
        begin
            scaled = VEL_W'(1);
        end
        else if (quot_reg > QUOT_W'(VEL_MAX))
        begin
            scaled = VEL_W'(VEL_MAX);
        end
        else
        begin
            scaled = quot_reg[VEL_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: rtl/dnh_core.sv
`default_nettype none

module dnh_core #(
    parameter int MAX_DEGREES = dnh_pkg::MAX_DEGREES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire dnh_pkg::cfg_t cfg,
    dnh_note_if.sink           note,
    dnh_harmony_if.source      harmony
);
    import dnh_pkg::*;

    localparam int TAB = (MAX_DEGREES > MAJOR_LEN) ? MAX_DEGREES : MAJOR_LEN;
    localparam int IW  = $clog2(TAB);
    localparam int CW  = $clog2(TAB + 1);
    localparam int XW  = IW + 2;

    state_t state_reg, state_next;

    logic [PITCH_W-1:0]      pitch_reg;
    logic [VEL_W-1:0]        vin_reg;
    logic [CHAN_W-1:0]       chan_reg;
    logic [TIME_W-1:0]       time_reg;
    logic [LEN_W-1:0]        len_reg;
    logic [3:0]              chroma_reg;
    logic signed [ACC_W-1:0] base_reg;
    logic [IW-1:0]           scan_reg;
    logic [IW-1:0]           best_reg;
    logic [6:0]              bestdiff_reg;
    logic [1:0]              k_reg;
    logic signed [XW-1:0]    idx_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [1:0]              e_reg;
    logic [2:0]              ok_reg;
    logic [PITCH_W-1:0]      slot_reg [0:2];

    logic                    out_valid_reg, out_valid_next;
    logic [PITCH_W-1:0]      out_pitch_reg;
    logic [VEL_W-1:0]        out_vel_reg;
    logic [CHAN_W-1:0]       out_chan_reg;
    logic [TIME_W-1:0]       out_time_reg;
    logic [LEN_W-1:0]        out_len_reg;
    logic                    out_last_reg;

    logic [VEL_W-1:0]        vel_scaled;
    logic [CW-1:0]           cnt;
    logic signed [XW-1:0]    cnt_s;
    logic [1:0]              nh;
    logic                    octave_mode;
    logic                    last_k;
    logic                    scan_done;
    logic [3:0]              scan_deg;
    logic [3:0]              wrap_deg;
    logic signed [4:0]       diff;
    logic [4:0]              absd;
    logic                    idx_hi;
    logic                    idx_lo;
    logic signed [ACC_W-1:0] final_p;
    logic signed [ACC_W-1:0] oct_p;
    logic [12:0]             pmul;
    logic [3:0]              pquot;
    logic [PITCH_W-1:0]      pmod_full;
    logic [3:0]              rmod;
    logic signed [4:0]       chd;
    logic [3:0]              ch;
    logic                    note_ready;
    logic                    proceed;
    logic                    load;
    logic                    last_e;

    function automatic logic [3:0] deg_at(input logic [IW-1:0] i);
        logic [3:0] r;
        if (cfg.size == '0)
        begin
            r = major_degree(i[2:0]);
        end
        else
        begin
            r = 4'(cfg.degrees >> {i, 2'b00});
        end
        return r;
    endfunction

    dnh_vel_scale u_vel (
        .clk      (clk),
        .velocity (vin_reg),
        .ratio    (cfg.ratio),
        .scaled   (vel_scaled)
    );

    always_comb
    begin
        if (cfg.size == '0)
        begin
            cnt = CW'(MAJOR_LEN);
        end
        else if (cfg.size > 4'(MAX_DEGREES))
        begin
            cnt = CW'(MAX_DEGREES);
        end
        else
        begin
            cnt = CW'(cfg.size);
        end
    end

    assign cnt_s       = $signed(XW'(cnt));
    assign nh          = harm_count(cfg.mode);
    assign octave_mode = (cfg.mode == MODE_OCT_UP) || (cfg.mode == MODE_OCT_DOWN);
    assign last_k      = (k_reg == nh - 2'd1);
    assign scan_done   = (CW'(scan_reg) == cnt - CW'(1));

    assign scan_deg = deg_at(scan_reg);
    assign diff     = $signed({1'b0, scan_deg}) - $signed({1'b0, chroma_reg});
    assign absd     = diff[4] ? 5'(-diff) : 5'(diff);

    assign idx_hi   = (idx_reg >= cnt_s);
    assign idx_lo   = idx_reg[XW-1];
    assign wrap_deg = deg_at(idx_reg[IW-1:0]);
    assign final_p  = acc_reg + $signed({{(ACC_W-4){1'b0}}, wrap_deg});

    assign oct_p = (cfg.mode == MODE_OCT_UP)
                 ? $signed(ACC_W'(pitch_reg)) + $signed(ACC_W'(OCTAVE))
                 : $signed(ACC_W'(pitch_reg)) - $signed(ACC_W'(OCTAVE));

    // The pitch class comes from a reciprocal multiply that is exact over the key range.
    assign pmul      = 13'(pitch_reg) * 13'd43;
    assign pquot     = pmul[12:9];
    assign pmod_full = pitch_reg - PITCH_W'(pquot) * PITCH_W'(OCTAVE);
    assign rmod      = (cfg.root >= 4'(OCTAVE)) ? cfg.root - 4'(OCTAVE) : cfg.root;
    assign chd       = $signed({1'b0, pmod_full[3:0]}) - $signed({1'b0, rmod});
    assign ch        = chd[4] ? 4'(chd + 5'sd12) : chd[3:0];

    always_comb
    begin
        case (e_reg)
            2'd0:    last_e = (ok_reg[2:1] == 2'b00);
            2'd1:    last_e = !ok_reg[2];
            default: last_e = 1'b1;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (note.valid)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = octave_mode ? ST_EMIT : ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_WRAP;
            end
            ST_WRAP:
            begin
                if (!idx_hi && !idx_lo)
                begin
                    state_next = last_k ? ST_EMIT : ST_SETUP;
                end
            end
            ST_EMIT:
            begin
                if (proceed && (e_reg == nh - 2'd1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        note_ready = (state_reg == ST_IDLE);
        proceed    = 1'b0;
        load       = 1'b0;
        if (state_reg == ST_EMIT)
        begin
            proceed = !ok_reg[e_reg] || !out_valid_reg || harmony.ready;
            load    = ok_reg[e_reg] && proceed;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (harmony.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (note.valid)
                begin
                    pitch_reg <= note.note_pitch;
                    vin_reg   <= note.note_velocity;
                    chan_reg  <= note.note_channel;
                    time_reg  <= note.note_time;
                    len_reg   <= note.note_length;
                end
            end
            ST_PREP:
            begin
                chroma_reg   <= ch;
                base_reg     <= $signed(ACC_W'(pitch_reg)) - $signed(ACC_W'(ch));
                scan_reg     <= '0;
                best_reg     <= '0;
                bestdiff_reg <= 7'(DIFF_INIT);
                ok_reg       <= '0;
                k_reg        <= '0;
                e_reg        <= '0;
            end
            ST_SCAN:
            begin
                if (7'(absd) < bestdiff_reg)
                begin
                    bestdiff_reg <= 7'(absd);
                    best_reg     <= scan_reg;
                end
                scan_reg <= scan_reg + IW'(1);
                if (scan_done && octave_mode)
                begin
                    slot_reg[0] <= oct_p[PITCH_W-1:0];
                    ok_reg[0]   <= pitch_ok(oct_p);
                end
            end
            ST_SETUP:
            begin
                idx_reg <= $signed({2'b00, best_reg}) + XW'(harm_offset(cfg.mode, k_reg));
                acc_reg <= base_reg;
            end
            ST_WRAP:
            begin
                if (idx_hi)
                begin
                    idx_reg <= idx_reg - cnt_s;
                    acc_reg <= acc_reg + $signed(ACC_W'(OCTAVE));
                end
                else if (idx_lo)
                begin
                    idx_reg <= idx_reg + cnt_s;
                    acc_reg <= acc_reg - $signed(ACC_W'(OCTAVE));
                end
                else
                begin
                    slot_reg[k_reg] <= final_p[PITCH_W-1:0];
                    ok_reg[k_reg]   <= pitch_ok(final_p);
                    k_reg           <= k_reg + 2'd1;
                end
            end
            ST_EMIT:
            begin
                if (proceed)
                begin
                    e_reg <= e_reg + 2'd1;
                end
            end
            default:
            begin
            end
        endcase

        if (load)
        begin
            out_pitch_reg <= slot_reg[e_reg];
            out_vel_reg   <= vel_scaled;
            out_chan_reg  <= chan_reg;
            out_time_reg  <= time_reg;
            out_len_reg   <= len_reg;
            out_last_reg  <= last_e;
        end
    end

    assign note.ready               = note_ready;
    assign harmony.valid            = out_valid_reg;
    assign harmony.harmony_pitch    = out_pitch_reg;
    assign harmony.harmony_velocity = out_vel_reg;
    assign harmony.harmony_channel  = out_chan_reg;
    assign harmony.harmony_time     = out_time_reg;
    assign harmony.harmony_length   = out_len_reg;
    assign harmony.last_of_run      = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/diatonic_note_harmonizer_top.sv
`default_nettype none

// Diatonic note harmonizer. Each note transfer yields up to three harmony note transfers
// carrying the note's channel, start time and length, with last_of_run set on the final one;
// a note whose harmonies all fall outside the key range yields none. The block takes one note
// at a time and is ready again once its last harmony is in the output register. A note passes
// through the pitch class, a nearest-degree scan over the scale degrees, then per harmony a
// set-up step, a step per octave wrap and a step to form the pitch (octave modes form it in
// the scan instead), and a hand-out per harmony, which the output can stall. The user must
// write configuration only while no note is in flight; the block itself does not enforce it.
module diatonic_note_harmonizer_top #(
    parameter int MAX_DEGREES = dnh_pkg::MAX_DEGREES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [dnh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dnh_pkg::CFG_DATA_W-1:0] cfg_data,
    dnh_note_if.sink                            note,
    dnh_harmony_if.source                       harmony
);
    import dnh_pkg::*;

    mode_t                 mode_reg;
    logic [3:0]            root_reg;
    logic [3:0]            size_reg;
    logic [CFG_DATA_W-1:0] degrees_reg;
    logic [RATIO_W-1:0]    ratio_reg;
    cfg_t                  cfg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_OCT_UP;
            root_reg    <= ROOT_RESET;
            size_reg    <= SIZE_RESET;
            degrees_reg <= DEGREES_RESET;
            ratio_reg   <= RATIO_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:    mode_reg    <= mode_t'(cfg_data[2:0]);
                CFG_ROOT:    root_reg    <= cfg_data[3:0];
                CFG_SIZE:    size_reg    <= cfg_data[3:0];
                CFG_DEGREES: degrees_reg <= cfg_data;
                CFG_RATIO:   ratio_reg   <= cfg_data[RATIO_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.mode    = mode_reg;
        cfg.root    = root_reg;
        cfg.size    = size_reg;
        cfg.degrees = degrees_reg;
        cfg.ratio   = ratio_reg;
    end

    dnh_core #(
        .MAX_DEGREES (MAX_DEGREES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .note    (note),
        .harmony (harmony)
    );

endmodule

`default_nettype wire

// File: tb/dnh_harmony_checker.sv
`timescale 1ns / 1ps

module dnh_harmony_checker
    import dnh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    dnh_note_if                   note,
    dnh_harmony_if                harmony,
    output int                    errors,
    output int                    pending,
    output int                    seen
);

    localparam int PERCENT    = 100;
    localparam int PITCH_MAX  = 127;
    localparam int REPORT_CAP = 40;

    typedef struct packed {
        logic [PITCH_W-1:0] pitch;
        logic [VEL_W-1:0]   velocity;
        logic [CHAN_W-1:0]  channel;
        logic [TIME_W-1:0]  start;
        logic [LEN_W-1:0]   length;
        logic               last;
    } harmony_t;

    mode_t                 mode;
    logic [3:0]            root;
    logic [3:0]            size;
    logic [CFG_DATA_W-1:0] degrees;
    logic [RATIO_W-1:0]    ratio;

    int       scale_steps [MAX_DEGREES_DEF];
    int       scale_len;
    harmony_t expected_q [$];
    int       fail_count    = 0;
    int       harmony_count = 0;

    task automatic report(input string msg);
        if (fail_count < REPORT_CAP)
            $display("%0t ns  harmony check: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report($sformatf("transfer %0d: %s is %0d, expected %0d",
                             harmony_count, name, got, want));
    endtask

    function automatic void enqueue_expected(input harmony_t h);
        expected_q.insert(expected_q.size(), h);
    endfunction

    function automatic void load_scale();
        int i;
        if (size == 0)
        begin
            // The major scale: whole tones, with a semitone after the third degree.
            scale_len = MAJOR_LEN;
            for (i = 0; i < MAJOR_LEN; i++)
                scale_steps[i] = (i < 3) ? 2 * i : 2 * i - 1;
        end
        else
        begin
            scale_len = (int'(size) > MAX_DEGREES_DEF) ? MAX_DEGREES_DEF : int'(size);
            for (i = 0; i < scale_len; i++)
                scale_steps[i] = int'(degrees[4*i +: 4]);
        end
    endfunction

    function automatic int degree_pitch(input int base, input int idx);
        int q;
        if (idx >= 0)
            q = idx / scale_len;
        else
            q = -((scale_len - 1 - idx) / scale_len);
        return base + scale_steps[idx - q * scale_len] + OCTAVE * q;
    endfunction

    function automatic void predict_harmonies(
        input logic [PITCH_W-1:0] key,
        input logic [VEL_W-1:0]   vel,
        input logic [CHAN_W-1:0]  chan,
        input logic [TIME_W-1:0]  start,
        input logic [LEN_W-1:0]   length
    );
        harmony_t h;
        int       cand [3];
        int       count, chroma, base, best, best_diff, diff, step, scaled, i, k, n;
        scaled = int'(vel) * int'(ratio) / PERCENT;
        if (scaled < 1)
            scaled = 1;
        if (scaled > VEL_MAX)
            scaled = VEL_MAX;
        h.velocity = VEL_W'(scaled);
        h.channel  = chan;
        h.start    = start;
        h.length   = length;
        h.last     = 1'b0;
        count = 1;
        if (mode == MODE_OCT_UP)
            cand[0] = int'(key) + OCTAVE;
        else if (mode == MODE_OCT_DOWN)
            cand[0] = int'(key) - OCTAVE;
        else
        begin
            load_scale();
            chroma    = ((int'(key) - int'(root)) % OCTAVE + OCTAVE) % OCTAVE;
            base      = int'(key) - chroma;
            best      = 0;
            best_diff = DIFF_INIT;
            for (i = 0; i < scale_len; i++)
            begin
                diff = scale_steps[i] - chroma;
                if (diff < 0)
                    diff = -diff;
                if (diff < best_diff)
                begin
                    best_diff = diff;
                    best      = i;
                end
            end
            if (mode == MODE_TRIAD)
                count = 2;
            else if (mode == MODE_SEVENTH)
                count = 3;
            for (k = 0; k < count; k++)
            begin
                step = 2 * (k + 1);
                if (mode == MODE_FIFTH_UP || mode == MODE_FIFTH_DOWN)
                    step = 4;
                if (mode == MODE_THIRD_DOWN || mode == MODE_FIFTH_DOWN)
                    step = -step;
                cand[k] = degree_pitch(base, best + step);
            end
        end
        n = 0;
        for (k = 0; k < count; k++)
            if (cand[k] >= 0 && cand[k] <= PITCH_MAX)
                n++;
        for (k = 0; k < count; k++)
            if (cand[k] >= 0 && cand[k] <= PITCH_MAX)
            begin
                n--;
                h.pitch = PITCH_W'(cand[k]);
                h.last  = (n == 0);
                enqueue_expected(h);
            end
    endfunction

    task automatic check_harmony();
        harmony_t want;
        harmony_count++;
        if (expected_q.size() == 0)
            report($sformatf("transfer %0d (pitch %0d) arrived with nothing expected",
                             harmony_count, harmony.harmony_pitch));
        else
        begin
            want = expected_q.pop_front();
            check_field("pitch", 32'(harmony.harmony_pitch), 32'(want.pitch));
            check_field("velocity", 32'(harmony.harmony_velocity), 32'(want.velocity));
            check_field("channel", 32'(harmony.harmony_channel), 32'(want.channel));
            check_field("start time", 32'(harmony.harmony_time), 32'(want.start));
            check_field("length", 32'(harmony.harmony_length), 32'(want.length));
            check_field("last_of_run", 32'(harmony.last_of_run), 32'(want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode    = MODE_OCT_UP;
            root    = ROOT_RESET;
            size    = SIZE_RESET;
            degrees = DEGREES_RESET;
            ratio   = RATIO_RESET;
            expected_q.delete();
        end
        else
        begin
            if (cfg_we)
                case (cfg_index)
                    CFG_MODE:    mode    = mode_t'(cfg_data[2:0]);
                    CFG_ROOT:    root    = cfg_data[3:0];
                    CFG_SIZE:    size    = cfg_data[3:0];
                    CFG_DEGREES: degrees = cfg_data;
                    CFG_RATIO:   ratio   = cfg_data[RATIO_W-1:0];
                    default:     ;
                endcase
            if (harmony.valid && harmony.ready)
                check_harmony();
            if (note.valid && note.ready)
                predict_harmonies(note.note_pitch, note.note_velocity, note.note_channel,
                                  note.note_time, note.note_length);
        end
        errors  <= fail_count;
        pending <= expected_q.size();
        seen    <= harmony_count;
    end

endmodule

// File: tb/diatonic_note_harmonizer_top_test.sv
`timescale 1ns / 1ps

module diatonic_note_harmonizer_top_test;
    import dnh_pkg::*;

    localparam logic [CFG_IDX_W-1:0]  CFG_SPARE     = 3'd6;
    localparam logic [CFG_DATA_W-1:0] CHROMATIC     = 48'hBA98_7654_3210;
    localparam logic [CFG_DATA_W-1:0] HIGH_STEPS    = 48'hFEDC_BA98_7654;
    localparam int                    SETTLE_CYCLES = 120;
    localparam int                    STALL_LIMIT   = 4000;
    localparam int                    IDLE_PERCENT  = 37;
    localparam int                    RANDOM_BLOCKS = 10;
    localparam int                    BLOCK_NOTES   = 13;
    localparam int                    STEADY_BLOCK  = 3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  steady;
    int                    errors, pending, seen;
    int                    notes_sent    = 0;
    int                    settings_used = 0;
    int                    quiet_cycles  = 0;

    dnh_note_if    note_ch ();
    dnh_harmony_if harm_ch ();

    diatonic_note_harmonizer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .note      (note_ch),
        .harmony   (harm_ch)
    );

    dnh_harmony_checker harmony_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .note      (note_ch),
        .harmony   (harm_ch),
        .errors    (errors),
        .pending   (pending),
        .seen      (seen)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        harm_ch.ready <= rst_n && (steady || $urandom_range(0, 99) >= IDLE_PERCENT);

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (note_ch.valid && note_ch.ready)
            || (harm_ch.valid && harm_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timed out with no transfer for %0d cycles.", quiet_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic apply_setting(input mode_t mode, input logic [3:0] root,
                                 input logic [3:0] size, input logic [CFG_DATA_W-1:0] degrees,
                                 input logic [RATIO_W-1:0] ratio, input bit poke_spare);
        if (poke_spare)
            write_reg(CFG_SPARE, CFG_DATA_W'({$urandom, $urandom}));
        write_reg(CFG_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_ROOT, CFG_DATA_W'(root));
        write_reg(CFG_SIZE, CFG_DATA_W'(size));
        write_reg(CFG_DEGREES, degrees);
        write_reg(CFG_RATIO, CFG_DATA_W'(ratio));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic random_setting(input mode_t mode, input bit poke_spare);
        logic [CFG_DATA_W-1:0] degrees;
        logic [RATIO_W-1:0]    ratio;
        int                    offset, i;
        // Half of the scales rise steadily, the rest are arbitrary nibbles.
        if ($urandom_range(0, 1))
        begin
            offset = 0;
            for (i = 0; i < MAX_DEGREES_DEF; i++)
            begin
                degrees[4*i +: 4] = offset[3:0];
                offset += $urandom_range(1, 2);
                if (offset > 15)
                    offset = 15;
            end
        end
        else
            degrees = CFG_DATA_W'({$urandom, $urandom});
        if ($urandom_range(0, 3) == 0)
            ratio = RATIO_W'($urandom_range(0, 511));
        else
            ratio = RATIO_W'($urandom_range(25, 200));
        apply_setting(mode, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), degrees,
                      ratio, poke_spare);
    endtask

    task automatic send_note(input logic [PITCH_W-1:0] key, input logic [VEL_W-1:0] vel);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            note_ch.valid <= 1'b0;
            @(posedge clk);
        end
        note_ch.valid         <= 1'b1;
        note_ch.note_pitch    <= key;
        note_ch.note_velocity <= vel;
        note_ch.note_channel  <= CHAN_W'($urandom_range(0, 15));
        note_ch.note_time     <= TIME_W'($urandom);
        note_ch.note_length   <= LEN_W'($urandom);
        do
            @(posedge clk);
        while (!note_ch.ready);
        notes_sent++;
    endtask

    task automatic settle();
        note_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [PITCH_W-1:0] pick_key();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? PITCH_W'($urandom_range(0, 15))
                                        : PITCH_W'($urandom_range(112, 127));
        return PITCH_W'($urandom_range(0, 127));
    endfunction

    function automatic logic [VEL_W-1:0] pick_velocity();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? VEL_W'(0) : VEL_W'(127);
        return VEL_W'($urandom_range(0, 127));
    endfunction

    initial
    begin
        int b, n;
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= '0;
        cfg_data              <= '0;
        steady                <= 1'b0;
        note_ch.valid         <= 1'b0;
        note_ch.note_pitch    <= '0;
        note_ch.note_velocity <= '0;
        note_ch.note_channel  <= '0;
        note_ch.note_time     <= '0;
        note_ch.note_length   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The reset settings first, then one setting for each mode and corner.
        send_note(127, 64);
        send_note(115, 0);
        send_note(0, 127);
        settle();
        apply_setting(MODE_OCT_DOWN, 4'd0, 4'd7, DEGREES_RESET, 9'd400, 1'b0);
        send_note(11, 127);
        send_note(12, 127);
        send_note(127, 1);
        settle();
        apply_setting(MODE_THIRD_UP, 4'd0, 4'd7, DEGREES_RESET, 9'd0, 1'b0);
        send_note(60, 100);
        send_note(61, 100);
        send_note(127, 100);
        settle();
        apply_setting(MODE_THIRD_DOWN, 4'd15, 4'd7, DEGREES_RESET, 9'd511, 1'b1);
        send_note(0, 127);
        send_note(64, 50);
        settle();
        apply_setting(MODE_FIFTH_UP, 4'd11, 4'd0, '0, 9'd100, 1'b0);
        send_note(125, 80);
        send_note(50, 80);
        settle();
        apply_setting(MODE_FIFTH_DOWN, 4'd3, 4'd15, HIGH_STEPS, 9'd150, 1'b0);
        send_note(5, 90);
        send_note(100, 90);
        settle();
        apply_setting(MODE_TRIAD, 4'd0, 4'd1, '0, 9'd100, 1'b0);
        send_note(60, 70);
        send_note(120, 70);
        settle();
        apply_setting(MODE_SEVENTH, 4'd5, 4'd12, CHROMATIC, 9'd50, 1'b0);
        send_note(127, 127);
        send_note(60, 3);
        send_note(115, 127);
        settle();

        for (b = 0; b < RANDOM_BLOCKS; b++)
        begin
            steady <= (b == STEADY_BLOCK);
            random_setting(mode_t'(b % 8), b == 5);
            for (n = 0; n < BLOCK_NOTES; n++)
                send_note(pick_key(), pick_velocity());
            settle();
        end

        $display("Sent %0d notes under %0d register settings; %0d harmony transfers checked.",
                 notes_sent, settings_used + 1, seen);
        $display("Covered all eight modes, default and saturated scales, high roots and keys.");
        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
